// ----- rtl/core/level_crossing_gate_controller_assert.svh -----
// ----------------------------------------------------------------------------
// Level crossing gate controller - assertion macros
// Shared property macros for the port checker.
// ----------------------------------------------------------------------------
`ifndef LEVEL_CROSSING_GATE_CONTROLLER_ASSERT_SVH
`define LEVEL_CROSSING_GATE_CONTROLLER_ASSERT_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define LCGC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lcgc assertion failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define LCGC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lcgc assertion failed");

`endif

// ----- rtl/core/lcgc_pkg.sv -----
// ----------------------------------------------------------------------------
// Level crossing gate controller - package
// Types, codes and constants shared by the controller files.
// ----------------------------------------------------------------------------
`default_nettype none

package lcgc_pkg;

   localparam int unsigned POS_W        = 7;
   localparam int unsigned TIMER_W      = 5;
   localparam int unsigned LDELAY_W     = 3;
   localparam int unsigned CODE_W       = 2;
   localparam int unsigned NUM_GATES    = 4;
   localparam int unsigned CSR_ADDR_W   = 5;
   localparam int unsigned CSR_DATA_W   = 32;

   localparam int unsigned COUNT_CAP_DEFAULT = 20;

   localparam logic [POS_W-1:0] GATE_MAX = 7'd90;

   // register reset values
   localparam logic [POS_W-1:0]    GATE_STEP_RST        = 7'd10;
   localparam logic [POS_W-1:0]    OPEN_LEVEL_RST       = 7'd80;
   localparam logic [POS_W-1:0]    CLOSED_LEVEL_RST     = 7'd10;
   localparam logic [TIMER_W-1:0]  APPROACH_TIMEOUT_RST = 5'd12;
   localparam logic [TIMER_W-1:0]  CLOSE_DELAY_RST      = 5'd4;
   localparam logic [LDELAY_W-1:0] LIGHT_DELAY_RST      = 3'd4;

   // gate raise flags
   localparam logic [NUM_GATES-1:0] FL_A   = 4'b0001;
   localparam logic [NUM_GATES-1:0] FL_B   = 4'b0010;
   localparam logic [NUM_GATES-1:0] FL_C   = 4'b0100;
   localparam logic [NUM_GATES-1:0] FL_D   = 4'b1000;
   localparam logic [NUM_GATES-1:0] FL_ALL = 4'b1111;

   // light codes on the output
   localparam logic [CODE_W-1:0] LIGHT_GREEN = 2'd1;
   localparam logic [CODE_W-1:0] LIGHT_AMBER = 2'd2;
   localparam logic [CODE_W-1:0] LIGHT_RED   = 2'd3;

   typedef enum logic [2:0] {
      CS_OPEN   = 3'd0,
      CS_CLOSE1 = 3'd1,
      CS_SETTLE = 3'd2,
      CS_CLOSE2 = 3'd3,
      CS_REOPEN = 3'd4,
      CS_FAULT  = 3'd5
   } ctrl_state_type;

   typedef enum logic [1:0] {
      LS_GREEN        = 2'd0,
      LS_AMBER_PRE    = 2'd1,
      LS_RED          = 2'd2,
      LS_AMBER_REOPEN = 2'd3
   } lamp_phase_type;

   typedef enum logic [2:0] {
      REG_GATE_STEP        = 3'd0,
      REG_OPEN_LEVEL       = 3'd1,
      REG_CLOSED_LEVEL     = 3'd2,
      REG_APPROACH_TIMEOUT = 3'd3,
      REG_CLOSE_DELAY      = 3'd4,
      REG_LIGHT_DELAY      = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic train_entered;
      logic train_exited;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]  gate_a_pos;
      logic [POS_W-1:0]  gate_b_pos;
      logic [POS_W-1:0]  gate_c_pos;
      logic [POS_W-1:0]  gate_d_pos;
      logic [CODE_W-1:0] light_code;
      logic              alarm;
   } rsp_type;

   typedef struct packed {
      logic [POS_W-1:0]    gate_step;
      logic [POS_W-1:0]    open_level;
      logic [POS_W-1:0]    closed_level;
      logic [TIMER_W-1:0]  approach_timeout;
      logic [TIMER_W-1:0]  close_delay;
      logic [LDELAY_W-1:0] light_delay;
   } cfg_type;

   // controller state apart from the tick counter, whose width follows COUNT_CAP
   typedef struct packed {
      ctrl_state_type                   ctrl_state;
      ctrl_state_type                   last_normal_state;
      logic [NUM_GATES-1:0]             raise_flags;
      logic                             alarm_flag;
      logic [NUM_GATES-1:0][POS_W-1:0]  gate_pos;
      lamp_phase_type                   lamp_phase;
      logic [LDELAY_W-1:0]              light_count;
      logic                             all_open_seen;
      logic                             gates_closed;
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/core/level_crossing_gate_controller.sv -----
// ----------------------------------------------------------------------------
// Level crossing gate controller - top level
// One tick per transaction: gate positions, light code and alarm per tick.
// ----------------------------------------------------------------------------
//
//   channel  ports          direction  carries
//   -------  -------------  ---------  ------------------------------------
//   req      req_valid/...  in         train_entered, train_exited (1 tick)
//   rsp      rsp_valid/...  out        four gate positions, light, alarm
//   csr      csr_psel/...   in/out     six config registers at 4*index
//
// One tick per cycle unless stalled: the whole tick is computed in one pass
// from the state registers and the request, and lands in the head or skid
// register at the same edge that accepts the transaction. The result side
// is a head register plus one skid register, so a stalled result never holds
// up the next request; req_stall rises only in reset or when both are full.
// Synchronous reset loads the chart states and register defaults at once;
// there is no clearing pass. Config writes are expected while idle.
//
`default_nettype none

module level_crossing_gate_controller #(
   parameter int unsigned COUNT_CAP = lcgc_pkg::COUNT_CAP_DEFAULT
) (
   input  wire                                clock,
   input  wire                                reset,

   input  wire                                req_valid,
   output logic                               req_stall,
   input  lcgc_pkg::req_type                  req_data,

   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output lcgc_pkg::rsp_type                  rsp_data,

   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire [lcgc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire [lcgc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [lcgc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import lcgc_pkg::*;

   // tick counter width follows the saturation cap
   localparam int unsigned TICK_W = $clog2(COUNT_CAP + 1);

   // ---------------------------------------------------------------- config
   cfg_type       cfg_ff, cfg_in;
   reg_index_type csr_index;
   logic          csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_GATE_STEP:        cfg_in.gate_step        = csr_pwdata[POS_W-1:0];
            REG_OPEN_LEVEL:       cfg_in.open_level       = csr_pwdata[POS_W-1:0];
            REG_CLOSED_LEVEL:     cfg_in.closed_level     = csr_pwdata[POS_W-1:0];
            REG_APPROACH_TIMEOUT: cfg_in.approach_timeout = csr_pwdata[TIMER_W-1:0];
            REG_CLOSE_DELAY:      cfg_in.close_delay      = csr_pwdata[TIMER_W-1:0];
            REG_LIGHT_DELAY:      cfg_in.light_delay      = csr_pwdata[LDELAY_W-1:0];
            default: ;  // writes past the register list are dropped
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_GATE_STEP:        csr_prdata = CSR_DATA_W'(cfg_ff.gate_step);
         REG_OPEN_LEVEL:       csr_prdata = CSR_DATA_W'(cfg_ff.open_level);
         REG_CLOSED_LEVEL:     csr_prdata = CSR_DATA_W'(cfg_ff.closed_level);
         REG_APPROACH_TIMEOUT: csr_prdata = CSR_DATA_W'(cfg_ff.approach_timeout);
         REG_CLOSE_DELAY:      csr_prdata = CSR_DATA_W'(cfg_ff.close_delay);
         REG_LIGHT_DELAY:      csr_prdata = CSR_DATA_W'(cfg_ff.light_delay);
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gate_step        <= GATE_STEP_RST;
         cfg_ff.open_level       <= OPEN_LEVEL_RST;
         cfg_ff.closed_level     <= CLOSED_LEVEL_RST;
         cfg_ff.approach_timeout <= APPROACH_TIMEOUT_RST;
         cfg_ff.close_delay      <= CLOSE_DELAY_RST;
         cfg_ff.light_delay      <= LIGHT_DELAY_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ----------------------------------------------------------- tick state
   // started_ff is clear until the first transaction; that tick only starts
   // both charts up (all gates raised, open, green) without any transition.
   logic              started_ff;
   state_type         state_ff, state_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   rsp_type           rsp_in;
   logic              push, pop;

   lcgc_step #(
      .COUNT_CAP (COUNT_CAP),
      .TICK_W    (TICK_W)
   ) u_lcgc_step (
      .first    (~started_ff),
      .cfg      (cfg_ff),
      .req      (req_data),
      .cur      (state_ff),
      .tick     (tick_ff),
      .nxt      (state_in),
      .tick_nxt (tick_in),
      .rsp      (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff                 <= 1'b0;
         state_ff.ctrl_state        <= CS_OPEN;
         state_ff.last_normal_state <= CS_OPEN;
         state_ff.raise_flags       <= FL_ALL;
         state_ff.alarm_flag        <= 1'b0;
         state_ff.gate_pos          <= {NUM_GATES{GATE_MAX}};
         state_ff.lamp_phase        <= LS_GREEN;
         state_ff.light_count       <= '0;
         state_ff.all_open_seen     <= 1'b0;
         state_ff.gates_closed      <= 1'b0;
         tick_ff                    <= '0;
      end else if (push) begin
         started_ff <= 1'b1;
         state_ff   <= state_in;
         tick_ff    <= tick_in;
      end
   end

   // ------------------------------------------------------- result buffer
   // head_ff drives the rsp port; skid_ff catches one transaction while the
   // head is stalled. skid is only ever valid behind a valid head.
   rsp_type head_ff, head_in, skid_ff, skid_in;
   logic    head_valid_ff, head_valid_in, skid_valid_ff, skid_valid_in;

   assign req_stall = reset | (head_valid_ff & skid_valid_ff);
   assign push      = req_valid & ~req_stall;
   assign rsp_valid = head_valid_ff;
   assign rsp_data  = head_ff;
   assign pop       = head_valid_ff & ~rsp_stall;

   always_comb begin
      head_in       = head_ff;
      head_valid_in = head_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!head_valid_ff || pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            head_valid_in = 1'b1;
            skid_in       = rsp_in;
            skid_valid_in = push;
         end else begin
            head_in       = rsp_in;
            head_valid_in = push;
         end
      end else if (push) begin
         skid_in       = rsp_in;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

// ----- rtl/core/lcgc_step.sv -----
// ----------------------------------------------------------------------------
// Level crossing gate controller - tick logic
// Next state and result for one tick: control chart, gate ramps, light chart.
// ----------------------------------------------------------------------------
`default_nettype none

module lcgc_step #(
   parameter int unsigned COUNT_CAP = lcgc_pkg::COUNT_CAP_DEFAULT,
   parameter int unsigned TICK_W    = $clog2(COUNT_CAP + 1)
) (
   input  wire                   first,
   input  lcgc_pkg::cfg_type     cfg,
   input  lcgc_pkg::req_type     req,
   input  lcgc_pkg::state_type   cur,
   input  wire [TICK_W-1:0]      tick,
   output lcgc_pkg::state_type   nxt,
   output logic [TICK_W-1:0]     tick_nxt,
   output lcgc_pkg::rsp_type     rsp
);
   import lcgc_pkg::*;

   localparam logic [TICK_W-1:0] CAP = TICK_W'(COUNT_CAP);

   function automatic logic [POS_W-1:0] move_gate(input logic [POS_W-1:0] pos,
                                                  input logic [POS_W-1:0] step,
                                                  input logic             raise);
      logic [POS_W:0] sum;
      sum = {1'b0, pos} + {1'b0, step};
      if (raise) begin
         return (sum > {1'b0, GATE_MAX}) ? GATE_MAX : sum[POS_W-1:0];
      end
      return (step > pos) ? '0 : pos - step;
   endfunction

   logic [TIMER_W-1:0] tick_ext;
   logic [TICK_W-1:0]  tick_up;
   logic               all_open;
   logic [CODE_W-1:0]  code;

   assign tick_ext = TIMER_W'(tick);
   assign tick_up  = (tick < CAP) ? tick + TICK_W'(1) : CAP;

   always_comb begin
      nxt      = cur;
      tick_nxt = tick;

      // control chart
      if (first) begin
         nxt.ctrl_state        = CS_OPEN;
         nxt.raise_flags       = FL_ALL;
         nxt.last_normal_state = CS_OPEN;
         nxt.alarm_flag        = 1'b0;
      end else begin
         unique case (cur.ctrl_state)
            CS_OPEN: begin
               nxt.raise_flags = FL_ALL;
               if (req.train_entered) begin
                  nxt.ctrl_state        = CS_CLOSE1;
                  nxt.raise_flags       = FL_B | FL_C;
                  nxt.last_normal_state = CS_CLOSE1;
                  tick_nxt              = '0;
                  nxt.alarm_flag        = 1'b0;
               end
            end
            CS_SETTLE: begin
               if (tick_ext > cfg.close_delay) begin
                  nxt.ctrl_state        = CS_CLOSE2;
                  nxt.raise_flags       = cur.raise_flags & ~(FL_B | FL_C);
                  nxt.last_normal_state = CS_CLOSE2;
                  tick_nxt              = '0;
                  nxt.alarm_flag        = 1'b0;
               end else begin
                  tick_nxt = tick_up;
               end
            end
            CS_CLOSE2: begin
               nxt.raise_flags = cur.raise_flags & ~(FL_B | FL_C);
               if (req.train_exited) begin
                  nxt.ctrl_state        = CS_REOPEN;
                  nxt.raise_flags       = FL_ALL;
                  nxt.last_normal_state = CS_REOPEN;
                  tick_nxt              = '0;
                  nxt.alarm_flag        = 1'b0;
               end else begin
                  tick_nxt = tick_up;
               end
            end
            CS_REOPEN: begin
               nxt.raise_flags = FL_ALL;
               if (cur.all_open_seen) begin
                  nxt.ctrl_state        = CS_OPEN;
                  nxt.last_normal_state = CS_OPEN;
                  nxt.alarm_flag        = 1'b0;
               end else if (tick_ext > cfg.approach_timeout) begin
                  nxt.ctrl_state = CS_FAULT;
                  nxt.alarm_flag = 1'b1;
               end else begin
                  tick_nxt = tick_up;
               end
            end
            CS_FAULT: begin
               if (cur.last_normal_state == CS_CLOSE1 && cur.gates_closed) begin
                  nxt.ctrl_state        = CS_SETTLE;
                  nxt.last_normal_state = CS_SETTLE;
                  tick_nxt              = '0;
                  nxt.alarm_flag        = 1'b0;
               end else if (cur.last_normal_state == CS_CLOSE2 && req.train_exited) begin
                  nxt.ctrl_state        = CS_REOPEN;
                  nxt.raise_flags       = FL_ALL;
                  nxt.last_normal_state = CS_REOPEN;
                  tick_nxt              = '0;
                  nxt.alarm_flag        = 1'b0;
               end else begin
                  nxt.alarm_flag = 1'b1;
               end
            end
            default: begin
               // closing first pair; unused codes behave the same
               nxt.raise_flags = cur.raise_flags & ~(FL_A | FL_D);
               if (tick_ext > cfg.approach_timeout) begin
                  nxt.ctrl_state = CS_FAULT;
                  nxt.alarm_flag = 1'b1;
               end else if (cur.gates_closed) begin
                  nxt.ctrl_state        = CS_SETTLE;
                  nxt.last_normal_state = CS_SETTLE;
                  tick_nxt              = '0;
                  nxt.alarm_flag        = 1'b0;
               end else begin
                  tick_nxt = tick_up;
               end
            end
         endcase
      end

      // gate ramps use the new raise flags
      for (int g = 0; g < NUM_GATES; g++) begin
         nxt.gate_pos[g] = move_gate(cur.gate_pos[g], cfg.gate_step, nxt.raise_flags[g]);
      end

      all_open = 1'b1;
      for (int g = 0; g < NUM_GATES; g++) begin
         if (nxt.gate_pos[g] < cfg.open_level) begin
            all_open = 1'b0;
         end
      end

      // light chart
      code = LIGHT_GREEN;
      if (first) begin
         nxt.lamp_phase = LS_GREEN;
         code           = LIGHT_GREEN;
      end else begin
         unique case (cur.lamp_phase)
            LS_GREEN: begin
               code = LIGHT_GREEN;
               if (req.train_entered) begin
                  nxt.lamp_phase  = LS_AMBER_PRE;
                  nxt.light_count = '0;
                  code            = LIGHT_AMBER;
               end
            end
            LS_AMBER_PRE: begin
               code = LIGHT_AMBER;
               if (cur.light_count >= cfg.light_delay) begin
                  nxt.lamp_phase = LS_RED;
                  code           = LIGHT_RED;
               end else begin
                  nxt.light_count = cur.light_count + LDELAY_W'(1);
               end
            end
            LS_RED: begin
               code = LIGHT_RED;
               if (req.train_exited) begin
                  nxt.lamp_phase = LS_AMBER_REOPEN;
                  code           = LIGHT_AMBER;
               end
            end
            default: begin
               code = LIGHT_AMBER;
               if (all_open) begin
                  nxt.lamp_phase    = LS_GREEN;
                  nxt.all_open_seen = 1'b1;
                  code              = LIGHT_GREEN;
               end
            end
         endcase
      end

      nxt.gates_closed = (nxt.gate_pos[0] < cfg.closed_level) &&
                         (nxt.gate_pos[3] < cfg.closed_level);

      rsp.gate_a_pos = nxt.gate_pos[0];
      rsp.gate_b_pos = nxt.gate_pos[1];
      rsp.gate_c_pos = nxt.gate_pos[2];
      rsp.gate_d_pos = nxt.gate_pos[3];
      rsp.light_code = code;
      rsp.alarm      = nxt.alarm_flag;
   end

endmodule

`default_nettype wire

// ----- rtl/core/lcgc_checker.sv -----
// ----------------------------------------------------------------------------
// Level crossing gate controller - port checker
// Watches the top-level ports; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

`include "level_crossing_gate_controller_assert.svh"

module lcgc_checker (
   input wire                 clock,
   input wire                 reset,
   input wire                 req_valid,
   input wire                 req_stall,
   input wire                 rsp_valid,
   input wire                 rsp_stall,
   input lcgc_pkg::rsp_type   rsp_data
);
   import lcgc_pkg::*;

   // gate ramps are clamped to the travel range
   `LCGC_ASSERT_NOW(a_pos_range, rsp_valid, rsp_data.gate_a_pos <= GATE_MAX && rsp_data.gate_b_pos <= GATE_MAX && rsp_data.gate_c_pos <= GATE_MAX && rsp_data.gate_d_pos <= GATE_MAX)

   // light code is never the unused zero code
   `LCGC_ASSERT_NOW(a_light_code, rsp_valid, rsp_data.light_code != 2'd0)

   // a stalled result holds
   `LCGC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // no result appears without an accepted transaction
   `LCGC_ASSERT_NEXT(a_no_phantom, !rsp_valid && !(req_valid && !req_stall), !rsp_valid)

endmodule

bind level_crossing_gate_controller lcgc_checker u_lcgc_checker (.*);

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Level crossing gate controller - testbench
// Drives train ticks through the request channel, predicts every tick's gate
// positions, light code and alarm from an in-bench copy of both charts, and
// checks each result transaction in order. Registers are set over the CSR
// port between phases and read back.
// ----------------------------------------------------------------------------
module tb_top;
   import lcgc_pkg::*;

   localparam int COUNT_CAP   = 20;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_CAP   = 40;

   // ---------------------------------------------------------------------
   // clock, reset and block ports; every input has a known value at time 0
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;

   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   level_crossing_gate_controller #(
      .COUNT_CAP   (COUNT_CAP)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ---------------------------------------------------------------------
   // run bookkeeping
   // ---------------------------------------------------------------------
   int unsigned cycle_count     = 0;
   int          mismatches      = 0;
   int          results_checked = 0;
   int          ticks_sent      = 0;
   int          passages        = 0;
   int          alarm_ticks     = 0;
   int          settings_loaded = 0;
   int          gap_pct         = 26;   // sender idle odds, percent per cycle
   int          stall_pct       = 26;   // receiver stall odds, percent per cycle

   // expected tick results, oldest first
   rsp_type crossing_outputs_due[$];

   // ---------------------------------------------------------------------
   // crossing predictor: register mirror and chart state
   // ---------------------------------------------------------------------
   int cfg_step, cfg_open, cfg_closed, cfg_timeout, cfg_cdelay, cfg_ldelay;

   bit                    started;
   ctrl_state_type        ctrl_now;
   ctrl_state_type        ctrl_last_normal;
   int                    tick_cnt;
   logic [NUM_GATES-1:0]  raise_mask;
   bit                    alarm_now;
   int                    gate_pos [NUM_GATES];
   lamp_phase_type        light_now;
   int                    amber_cnt;
   bit                    all_open_latched;   // sticky, never cleared after reset
   bit                    closed_reg;         // seen by the control chart one tick late

   task automatic reset_crossing();
      cfg_step    = GATE_STEP_RST;
      cfg_open    = OPEN_LEVEL_RST;
      cfg_closed  = CLOSED_LEVEL_RST;
      cfg_timeout = APPROACH_TIMEOUT_RST;
      cfg_cdelay  = CLOSE_DELAY_RST;
      cfg_ldelay  = LIGHT_DELAY_RST;
      started          = 1'b0;
      ctrl_now         = CS_OPEN;
      ctrl_last_normal = CS_OPEN;
      tick_cnt         = 0;
      raise_mask       = FL_ALL;
      alarm_now        = 1'b0;
      for (int i = 0; i < NUM_GATES; i++) gate_pos[i] = GATE_MAX;
      light_now        = LS_GREEN;
      amber_cnt        = 0;
      all_open_latched = 1'b0;
      closed_reg       = 1'b0;
   endtask

   // tick counter holds at the cap
   function automatic void bump_tick_count();
      if (tick_cnt < COUNT_CAP) tick_cnt++;
      else tick_cnt = COUNT_CAP;
   endfunction

   function automatic void start_reopening();
      ctrl_now         = CS_REOPEN;
      raise_mask       = FL_ALL;
      ctrl_last_normal = CS_REOPEN;
      tick_cnt         = 0;
      alarm_now        = 1'b0;
   endfunction

   function automatic void start_settling();
      ctrl_now         = CS_SETTLE;
      tick_cnt         = 0;
      ctrl_last_normal = CS_SETTLE;
      alarm_now        = 1'b0;
   endfunction

   // one tick of the crossing: control chart, gate ramps, light chart
   task automatic advance_crossing(input req_type rq, output rsp_type rs);
      bit                first;
      int                p;
      logic [CODE_W-1:0] code;
      first = !started;
      if (first) begin
         // start-up tick: charts enter their initial states, inputs ignored
         started          = 1'b1;
         ctrl_now         = CS_OPEN;
         raise_mask       = FL_ALL;
         ctrl_last_normal = CS_OPEN;
         alarm_now        = 1'b0;
      end else begin
         case (ctrl_now)
            CS_OPEN: begin
               raise_mask = FL_ALL;
               if (rq.train_entered) begin
                  ctrl_now         = CS_CLOSE1;
                  raise_mask       = FL_B | FL_C;
                  ctrl_last_normal = CS_CLOSE1;
                  tick_cnt         = 0;
                  alarm_now        = 1'b0;
               end
            end
            CS_SETTLE: begin
               if (tick_cnt > cfg_cdelay) begin
                  ctrl_now         = CS_CLOSE2;
                  raise_mask      &= ~(FL_B | FL_C);
                  tick_cnt         = 0;
                  ctrl_last_normal = CS_CLOSE2;
                  alarm_now        = 1'b0;
               end else bump_tick_count();
            end
            CS_CLOSE2: begin
               raise_mask &= ~(FL_B | FL_C);
               if (rq.train_exited) start_reopening();
               else bump_tick_count();
            end
            CS_REOPEN: begin
               raise_mask = FL_ALL;
               if (all_open_latched) begin
                  ctrl_now         = CS_OPEN;
                  ctrl_last_normal = CS_OPEN;
                  alarm_now        = 1'b0;
               end else if (tick_cnt > cfg_timeout) begin
                  ctrl_now  = CS_FAULT;
                  alarm_now = 1'b1;
               end else bump_tick_count();
            end
            CS_FAULT: begin
               if (ctrl_last_normal == CS_CLOSE1 && closed_reg) start_settling();
               else if (ctrl_last_normal == CS_CLOSE2 && rq.train_exited) start_reopening();
               else alarm_now = 1'b1;
            end
            default: begin
               // closing first pair; spare codes land here too
               raise_mask &= ~(FL_A | FL_D);
               if (tick_cnt > cfg_timeout) begin
                  ctrl_now  = CS_FAULT;
                  alarm_now = 1'b1;
               end else if (closed_reg) start_settling();
               else bump_tick_count();
            end
         endcase
      end

      // signed compare against the travel limit, so a ramp below zero clamps low
      for (int i = 0; i < NUM_GATES; i++) begin
         p = raise_mask[i] ? gate_pos[i] + cfg_step : gate_pos[i] - cfg_step;
         if (p > int'(GATE_MAX)) p = int'(GATE_MAX);
         else if (p < 0) p = 0;
         gate_pos[i] = p;
      end

      if (first) begin
         light_now = LS_GREEN;
         code      = LIGHT_GREEN;
      end else begin
         case (light_now)
            LS_GREEN: begin
               code = LIGHT_GREEN;
               if (rq.train_entered) begin
                  light_now = LS_AMBER_PRE;
                  code      = LIGHT_AMBER;
                  amber_cnt = 0;
               end
            end
            LS_AMBER_PRE: begin
               code = LIGHT_AMBER;
               if (amber_cnt >= cfg_ldelay) begin
                  light_now = LS_RED;
                  code      = LIGHT_RED;
               end else amber_cnt = (amber_cnt + 1) & 7;
            end
            LS_RED: begin
               code = LIGHT_RED;
               if (rq.train_exited) begin
                  light_now = LS_AMBER_REOPEN;
                  code      = LIGHT_AMBER;
               end
            end
            default: begin
               code = LIGHT_AMBER;
               if (gate_pos[0] >= cfg_open && gate_pos[1] >= cfg_open &&
                   gate_pos[2] >= cfg_open && gate_pos[3] >= cfg_open) begin
                  light_now        = LS_GREEN;
                  code             = LIGHT_GREEN;
                  all_open_latched = 1'b1;
               end
            end
         endcase
      end

      closed_reg = gate_pos[0] < cfg_closed && gate_pos[3] < cfg_closed;

      rs.gate_a_pos = gate_pos[0][POS_W-1:0];
      rs.gate_b_pos = gate_pos[1][POS_W-1:0];
      rs.gate_c_pos = gate_pos[2][POS_W-1:0];
      rs.gate_d_pos = gate_pos[3][POS_W-1:0];
      rs.light_code = code;
      rs.alarm      = alarm_now;
   endtask

   // ---------------------------------------------------------------------
   // mismatch reporting; printing stops after a while, counting does not
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_CAP) $display("[%0d] ERROR: %s", cycle_count, msg);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d field %s: got %0d, expected %0d",
                                   results_checked, name, got, want));
   endtask

   // ---------------------------------------------------------------------
   // result side: sample at the falling edge, take at the rising edge
   // ---------------------------------------------------------------------
   bit      result_taken;
   rsp_type result_seen;

   always @(negedge clock) begin
      result_taken = (reset === 1'b0) && (rsp_valid === 1'b1) && (rsp_stall === 1'b0);
      result_seen  = rsp_data;
   end

   task automatic check_tick_result(input rsp_type got);
      rsp_type want;
      if (crossing_outputs_due.size() == 0) begin
         report_mismatch("result transaction with no tick outstanding");
      end else begin
         want = crossing_outputs_due.pop_front();
         compare_field("gate_a_pos", 32'(got.gate_a_pos), 32'(want.gate_a_pos));
         compare_field("gate_b_pos", 32'(got.gate_b_pos), 32'(want.gate_b_pos));
         compare_field("gate_c_pos", 32'(got.gate_c_pos), 32'(want.gate_c_pos));
         compare_field("gate_d_pos", 32'(got.gate_d_pos), 32'(want.gate_d_pos));
         compare_field("light_code", 32'(got.light_code), 32'(want.light_code));
         compare_field("alarm",      32'(got.alarm),      32'(want.alarm));
      end
      results_checked++;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (result_taken) check_tick_result(result_seen);
      rsp_stall <= !reset && ($urandom_range(0, 99) < stall_pct);
   end

   // watchdog: a hung handshake ends the run here
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d ticks outstanding",
               cycle_count, crossing_outputs_due.size());
      $display("level_crossing_gate_controller: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------------
   // request side: one tick transaction per call, random idle in front;
   // acceptance is decided by the stall value seen at the falling edge
   // ---------------------------------------------------------------------
   task automatic send_tick(input logic entered, input logic exited);
      req_type rq;
      rsp_type due;
      bit      taken;
      rq.train_entered = entered;
      rq.train_exited  = exited;
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      do begin
         @(negedge clock);
         taken = (req_stall === 1'b0);
         @(posedge clock);
      end while (!taken);
      advance_crossing(rq, due);
      crossing_outputs_due.push_back(due);
      if (due.alarm) alarm_ticks++;
      ticks_sent++;
   endtask

   // hold off the sender until every outstanding tick has come back
   task automatic wait_crossing_drained();
      req_valid <= 1'b0;
      while (crossing_outputs_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);   // leave margin after the last result
   endtask

   // ---------------------------------------------------------------------
   // CSR access: setup cycle, access cycle, then idle cycle
   // ---------------------------------------------------------------------
   function automatic logic [31:0] setting_of(input reg_index_type idx);
      case (idx)
         REG_GATE_STEP:        return cfg_step;
         REG_OPEN_LEVEL:       return cfg_open;
         REG_CLOSED_LEVEL:     return cfg_closed;
         REG_APPROACH_TIMEOUT: return cfg_timeout;
         REG_CLOSE_DELAY:      return cfg_cdelay;
         default:              return cfg_ldelay;
      endcase
   endfunction

   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      logic [CSR_ADDR_W-1:0] addr;
      addr = CSR_ADDR_W'(4 * idx);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(negedge clock); while (csr_pready !== 1'b1);
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      // the block keeps only the register's width
      case (idx)
         REG_GATE_STEP:        cfg_step    = value[POS_W-1:0];
         REG_OPEN_LEVEL:       cfg_open    = value[POS_W-1:0];
         REG_CLOSED_LEVEL:     cfg_closed  = value[POS_W-1:0];
         REG_APPROACH_TIMEOUT: cfg_timeout = value[TIMER_W-1:0];
         REG_CLOSE_DELAY:      cfg_cdelay  = value[TIMER_W-1:0];
         default:              cfg_ldelay  = value[LDELAY_W-1:0];
      endcase
      @(posedge clock);
   endtask

   task automatic csr_readback(input reg_index_type idx);
      logic [CSR_ADDR_W-1:0] addr;
      logic [31:0]           data;
      addr = CSR_ADDR_W'(4 * idx);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(negedge clock); while (csr_pready !== 1'b1);
      data = csr_prdata;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (data !== setting_of(idx))
         report_mismatch($sformatf("register %s reads %0h, expected %0h",
                                   idx.name(), data, setting_of(idx)));
      @(posedge clock);
   endtask

   // load all six registers while idle (junk above each field), then read back
   task automatic apply_settings(input int g_step, input int lvl_open, input int lvl_closed,
                                 input int t_out, input int c_delay, input int l_delay);
      wait_crossing_drained();
      csr_write(REG_GATE_STEP,        32'(g_step)     | ($urandom << POS_W));
      csr_write(REG_OPEN_LEVEL,       32'(lvl_open)   | ($urandom << POS_W));
      csr_write(REG_CLOSED_LEVEL,     32'(lvl_closed) | ($urandom << POS_W));
      csr_write(REG_APPROACH_TIMEOUT, 32'(t_out)      | ($urandom << TIMER_W));
      csr_write(REG_CLOSE_DELAY,      32'(c_delay)    | ($urandom << TIMER_W));
      csr_write(REG_LIGHT_DELAY,      32'(l_delay)    | ($urandom << LDELAY_W));
      for (int i = 0; i <= REG_LIGHT_DELAY; i++) csr_readback(reg_index_type'(i));
      settings_loaded++;
   endtask

   // ---------------------------------------------------------------------
   // traffic shapes
   // ---------------------------------------------------------------------
   // a train passage: quiet lead-in, entry, time in the zone, exit, quiet tail
   task automatic send_passage();
      int lead, zone, trail;
      lead  = $urandom_range(0, 6);
      zone  = $urandom_range(0, 36);
      trail = $urandom_range(0, 20);
      passages++;
      repeat (lead) send_tick(1'b0, 1'b0);
      send_tick(1'b1, $urandom_range(0, 9) == 0);   // now and then exit on the same tick
      repeat (zone) begin
         if ($urandom_range(0, 9) == 0)
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         else send_tick(1'b0, 1'b0);
      end
      if ($urandom_range(0, 9) != 0) send_tick(1'b0, 1'b1);   // exit sometimes lost
      repeat (trail) send_tick(1'b0, 1'b0);
      if (passages % 7 == 0) wait_crossing_drained();        // sender pause, pipe empties
   endtask

   task automatic run_phase(input int g_step, input int lvl_open, input int lvl_closed,
                            input int t_out, input int c_delay, input int l_delay,
                            input int n_ticks);
      int stop_at;
      apply_settings(g_step, lvl_open, lvl_closed, t_out, c_delay, l_delay);
      stop_at = ticks_sent + n_ticks;
      while (ticks_sent < stop_at) begin
         if ($urandom_range(0, 99) < 80) send_passage();
         else repeat ($urandom_range(1, 6))
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   task automatic test_csr_defaults();
      for (int i = 0; i <= REG_LIGHT_DELAY; i++) csr_readback(reg_index_type'(i));
   endtask

   // start-up tick, then one clean passage that sets the sticky all-open flag
   task automatic test_directed_passage();
      apply_settings(45, 80, 10, 12, 0, 0);
      send_tick(1'b1, 1'b1);            // start-up: both flags ignored, step hits the clamp
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);            // entry: first pair starts down, amber
      repeat (5) send_tick(1'b0, 1'b0); // closed flag registered, settle, second pair
      send_tick(1'b0, 1'b1);            // exit: reopen, amber
      repeat (3) send_tick(1'b0, 1'b0); // all open, green, back to open
   endtask

   // approach timeout while closing, recovery to settle once the gates close;
   // the reopen after this passage leaves on its first tick (sticky all-open)
   task automatic test_close_timeout_fault();
      apply_settings(45, 80, 10, 0, 0, 3);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b1);            // early exit: ignored by both charts
      repeat (6) send_tick(1'b0, 1'b0); // timeout, fault, settle, second pair
      send_tick(1'b0, 1'b1);
      repeat (3) send_tick(1'b0, 1'b0);
   endtask

   task automatic test_random_traffic();
      // reset values, back to back on both sides
      gap_pct   = 0;
      stall_pct = 0;
      run_phase(GATE_STEP_RST, OPEN_LEVEL_RST, CLOSED_LEVEL_RST,
                APPROACH_TIMEOUT_RST, CLOSE_DELAY_RST, LIGHT_DELAY_RST, 130);
      gap_pct   = 26;
      stall_pct = 26;
      run_phase(90, 90, 90, 19, 19, 7, 130);      // top of every range
      run_phase(1, 0, 90, 0, 0, 0, 130);          // bottom of every range but the closed level, which is at its top
      run_phase(90, 0, 0, 19, 0, 7, 60);          // closed level 0: closing never completes
      run_phase(127, 127, 127, 31, 31, 7, 60);    // past the documented ranges, light delay at its top
      run_phase(0, $urandom_range(0, 90), $urandom_range(1, 90),
                $urandom_range(0, 19), $urandom_range(0, 19), $urandom_range(0, 7), 60);
      repeat (4)
         run_phase($urandom_range(1, 90), $urandom_range(0, 90), $urandom_range(1, 90),
                   $urandom_range(0, 19), $urandom_range(0, 19), $urandom_range(0, 7), 55);
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset_crossing();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_csr_defaults();
      test_directed_passage();
      test_close_timeout_fault();
      test_random_traffic();

      // every tick back, then a short tail to catch stray result transactions
      wait_crossing_drained();
      repeat (8) @(posedge clock);

      $display("checked %0d tick results over %0d train passages, %0d with the alarm up",
               results_checked, passages, alarm_ticks);
      $display("%0d register settings loaded, range extremes and out-of-range values included",
               settings_loaded);
      if (mismatches == 0) begin
         $display("level_crossing_gate_controller: match");
      end else begin
         $display("level_crossing_gate_controller: mismatch");
      end
      $finish;
   end

endmodule
